>>> src/npcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcs_pkg: shared definitions for the nearest palette color search
// Types, codes and the distance function used by the scan engine and the top.
// ----------------------------------------------------------------------------
package npcs_pkg;

    // Palette geometry.
    localparam int PALETTE_DEPTH = 256;
    localparam int ADDR_W        = $clog2(PALETTE_DEPTH);
    localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);
    localparam int CHAN_W        = 8;
    localparam int ENTRY_W       = 3 * CHAN_W;
    localparam int IDX_W         = 8;
    // A scan covers no more than the store holds and the index field reaches.
    localparam int SCAN_MAX      = (PALETTE_DEPTH < (1 << IDX_W))
                                 ? PALETTE_DEPTH : (1 << IDX_W);

    // Configuration register file.
    localparam int NUMC_W               = 9;
    localparam logic [NUMC_W-1:0] NUMC_RESET = 9'd256;
    localparam logic REG_NUM_COLORS     = 1'b0;

    // Command codes carried by the func field.
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // The best distance starts here, so only closer entries replace index 0.
    localparam logic [CHAN_W-1:0] START_DIST = 8'd255;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_color;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] index;
    } t_scan_res;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_scan_state;

    function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

    // Chebyshev distance: the largest of the three channel differences.
    function automatic logic [CHAN_W-1:0] cheb_dist(input t_color e, input t_color q);
        logic [CHAN_W-1:0] dr;
        logic [CHAN_W-1:0] dg;
        logic [CHAN_W-1:0] db;
        logic [CHAN_W-1:0] m;
        dr = abs_diff(e.red, q.red);
        dg = abs_diff(e.green, q.green);
        db = abs_diff(e.blue, q.blue);
        m  = (dr > dg) ? dr : dg;
        cheb_dist = (m > db) ? m : db;
    endfunction

endpackage

>>> src/npcs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcs_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module npcs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/npcs_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcs_scan: palette scan engine
// Streams palette reads and tracks the nearest entry under Chebyshev distance.
// ----------------------------------------------------------------------------
module npcs_scan (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  npcs_pkg::t_color                 i_query,
    input  logic [npcs_pkg::CNT_W-1:0]       i_limit,
    output logic                             o_rd_en,
    output logic [npcs_pkg::ADDR_W-1:0]      o_rd_addr,
    input  logic [npcs_pkg::ENTRY_W-1:0]     i_rd_data,
    output logic                             o_busy,
    output npcs_pkg::t_scan_res              o_res
);

    npcs_pkg::t_scan_state              r_state, n_state;
    logic [npcs_pkg::CNT_W-1:0]         r_rd_idx, n_rd_idx;
    logic                               r_cmp_vld, n_cmp_vld;
    logic [npcs_pkg::ADDR_W-1:0]        r_cmp_idx, n_cmp_idx;
    logic [npcs_pkg::CHAN_W-1:0]        r_best, n_best;
    logic [npcs_pkg::ADDR_W-1:0]        r_best_idx, n_best_idx;
    logic                               r_res_vld, n_res_vld;
    logic [npcs_pkg::IDX_W-1:0]         r_res_idx, n_res_idx;
    npcs_pkg::t_color                   r_query, n_query;
    logic [npcs_pkg::CHAN_W-1:0]        cand_dist;
    logic                               last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= npcs_pkg::ST_IDLE;
            r_cmp_vld <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= n_cmp_vld;
            r_res_vld <= n_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx   <= n_rd_idx;
        r_cmp_idx  <= n_cmp_idx;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_res_idx  <= n_res_idx;
        r_query    <= n_query;
    end

    assign cand_dist = npcs_pkg::cheb_dist(npcs_pkg::t_color'(i_rd_data), r_query);
    assign last = ((npcs_pkg::CNT_W'(r_cmp_idx) + npcs_pkg::CNT_W'(1)) == i_limit);

    always_comb begin
        n_state    = r_state;
        n_rd_idx   = r_rd_idx;
        n_cmp_vld  = 1'b0;
        n_cmp_idx  = r_rd_idx[npcs_pkg::ADDR_W-1:0];
        n_best     = r_best;
        n_best_idx = r_best_idx;
        n_res_vld  = 1'b0;
        n_res_idx  = r_res_idx;
        n_query    = r_query;
        o_rd_en    = 1'b0;
        case (r_state)
            npcs_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_query = i_query;
                    if (i_limit == '0) begin
                        n_res_vld = 1'b1;
                        n_res_idx = '0;
                    end else begin
                        n_state    = npcs_pkg::ST_SCAN;
                        n_rd_idx   = '0;
                        n_best     = npcs_pkg::START_DIST;
                        n_best_idx = '0;
                    end
                end
            end
            npcs_pkg::ST_SCAN: begin
                o_rd_en   = (r_rd_idx < i_limit);
                n_cmp_vld = o_rd_en;
                if (o_rd_en) begin
                    n_rd_idx = r_rd_idx + npcs_pkg::CNT_W'(1);
                end
                if (r_cmp_vld) begin
                    if (cand_dist == '0) begin
                        // An exact match ends the scan at once.
                        n_state   = npcs_pkg::ST_IDLE;
                        n_cmp_vld = 1'b0;
                        n_res_vld = 1'b1;
                        n_res_idx = npcs_pkg::IDX_W'(r_cmp_idx);
                    end else begin
                        if (cand_dist < r_best) begin
                            n_best     = cand_dist;
                            n_best_idx = r_cmp_idx;
                        end
                        if (last) begin
                            n_state   = npcs_pkg::ST_IDLE;
                            n_cmp_vld = 1'b0;
                            n_res_vld = 1'b1;
                            n_res_idx = (cand_dist < r_best)
                                      ? npcs_pkg::IDX_W'(r_cmp_idx)
                                      : npcs_pkg::IDX_W'(r_best_idx);
                        end
                    end
                end
            end
            default: begin
                n_state = npcs_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_rd_addr   = r_rd_idx[npcs_pkg::ADDR_W-1:0];
    assign o_busy      = (r_state == npcs_pkg::ST_SCAN);
    assign o_res.valid = r_res_vld;
    assign o_res.index = r_res_idx;

endmodule

>>> src/nearest_palette_color_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_palette_color_search: nearest palette entry under Chebyshev distance
// Keeps a 256-entry RGB palette and answers nearest-color queries.
// ----------------------------------------------------------------------------
// A transaction is accepted at a rising edge where start is high and busy is
// low. A write transaction (func 0) stores one palette entry and produces no
// result; busy never rises for it. A query transaction (func 1) scans entries
// 0 to N-1, where N is num_colors clamped to 256, one palette memory read per
// cycle. Busy is high during the scan, and the result appears on
// o_color_index with o_done high for exactly one cycle as busy falls. An exact
// match at entry k ends the scan early; with N of zero the result (index 0)
// follows in the next cycle. The result cannot be held off: capture it in the
// cycle o_done is high. A new transaction may be accepted in that same cycle.
// The palette memory has no reset; query only entries that have been written.
// num_colors sits at byte address 0 of the APB port and resets to 256; write
// it only while no query is in progress.
// ----------------------------------------------------------------------------
module nearest_palette_color_search (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Command channel.
    input  logic        start,
    output logic        busy,
    input  logic        i_func,
    input  logic [7:0]  i_entry_index,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    // Result channel.
    output logic        o_done,
    output logic [7:0]  o_color_index,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [npcs_pkg::NUMC_W-1:0]  r_num_colors;
    logic [npcs_pkg::CNT_W-1:0]   limit;
    logic                         accept;
    logic                         ram_we;
    logic                         scan_start;
    logic                         rd_en;
    logic [npcs_pkg::ADDR_W-1:0]  rd_addr;
    logic [npcs_pkg::ENTRY_W-1:0] rd_data;
    npcs_pkg::t_color             cmd_color;
    npcs_pkg::t_scan_res          scan_res;
    logic                         scan_busy;

    // Configuration register. The word index is paddr[2]; only word 0 exists.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_colors <= npcs_pkg::NUMC_RESET;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == npcs_pkg::REG_NUM_COLORS)) begin
            r_num_colors <= pwdata[npcs_pkg::NUMC_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == npcs_pkg::REG_NUM_COLORS)
                  ? 32'(r_num_colors) : 32'd0;

    // The scan never runs past the palette or past what an index can name.
    assign limit = (32'(r_num_colors) > npcs_pkg::SCAN_MAX)
                 ? npcs_pkg::CNT_W'(npcs_pkg::SCAN_MAX)
                 : npcs_pkg::CNT_W'(r_num_colors);

    assign accept     = start && !busy;
    assign scan_start = accept && (i_func == npcs_pkg::FUNC_QUERY);
    // Writes are only taken while idle, so they never race a scan read.
    assign ram_we     = accept && (i_func == npcs_pkg::FUNC_WRITE)
                        && (32'(i_entry_index) < npcs_pkg::PALETTE_DEPTH);

    assign cmd_color.red   = i_red;
    assign cmd_color.green = i_green;
    assign cmd_color.blue  = i_blue;

    npcs_ram #(
        .WIDTH (npcs_pkg::ENTRY_W),
        .DEPTH (npcs_pkg::PALETTE_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (npcs_pkg::ADDR_W'(i_entry_index)),
        .i_wdata (cmd_color),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    npcs_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (scan_start),
        .i_query   (cmd_color),
        .i_limit   (limit),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_busy    (scan_busy),
        .o_res     (scan_res)
    );

    assign busy          = scan_busy;
    assign o_done        = scan_res.valid;
    assign o_color_index = scan_res.index;

    // A result only follows a scan or a query on an empty palette.
    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(busy) || $past(start && i_func)))
        else $error("result strobe without a query in flight");

    // The end of a scan always delivers its result in the same cycle.
    a_fall_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(busy)) |-> o_done)
        else $error("scan ended without a result");

    // The palette is never written while it is being scanned.
    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !ram_we)
        else $error("palette written during a scan");

    // Reads stay inside the configured scan length.
    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> (npcs_pkg::CNT_W'(rd_addr) < limit))
        else $error("palette read beyond the scan length");

endmodule
